// ===== design/orthogonal_forward_projector_unit_defines.svh =====
`ifndef ORTHOGONAL_FORWARD_PROJECTOR_UNIT_DEFINES_SVH
`define ORTHOGONAL_FORWARD_PROJECTOR_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define OFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define OFP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/ofp_pkg.sv =====
`timescale 1ns / 1ps

package ofp_pkg;

  localparam int MAX_X_DEF = 32;
  localparam int MAX_Y_DEF = 32;
  localparam int MAX_Z_DEF = 32;

  localparam int COEF_W   = 32;
  localparam int PITCH_W  = 31;
  localparam int SUM_W    = 48;
  localparam int VOX_W    = 32;
  localparam int SIZE_W   = 6;
  localparam int ORIG_W   = 16;
  localparam int COORD_W  = 17;
  localparam int Q_W      = 17;
  localparam int RAD_W    = 2 * Q_W;
  localparam int REM_W    = Q_W + 4;
  localparam int DIV_LAT  = Q_W;
  localparam int SQRT_LAT = Q_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

  typedef enum logic [1:0] {
    OP_LOAD_OUT = 2'd0,
    OP_LOAD_IN  = 2'd1,
    OP_EVENT    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X   = 3'd0,
    REG_SIZE_Y   = 3'd1,
    REG_SIZE_Z   = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4,
    REG_ORIGIN_Z = 3'd5
  } reg_e;

endpackage

// ===== design/orthogonal_forward_projector_unit.sv =====
`timescale 1ns / 1ps
`include "orthogonal_forward_projector_unit_defines.svh"
// PET orthogonal-distance forward projector.
// Input channel (in_valid_i / in_stall_o): op 0/1 loads one voxel value and
// its mask bit at the internal write pointer (raster order, z fastest),
// op 2 projects one event, op 3 is taken and dropped. An event walks
// every voxel of the size_x*size_y*size_z sub-volume (each size capped at
// its MAX), one voxel per cycle out of the image memory, through a pipeline
// (products, plane sums, two 17-stage dividers, a 17-stage square root,
// weighting and a saturating accumulator). The sum word of an event appears
// once the walk is done and the pipeline has drained (sooner when the last
// voxels are masked out or miss the planes), and the next item is taken
// after the word is registered.
// Output channel (out_valid_o / out_stall_i): one sum word per event, held
// in an output register; the next item is taken while it waits, and a
// finished event waits only if the previous word is still stalled.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; the user must
// see it written only while idle (unenforced by the block). Reset clears the
// write pointer, sizes to 32, origins to 0; image memory is unset until loaded.
module orthogonal_forward_projector_unit import ofp_pkg::*; #(
  parameter int MAX_X = MAX_X_DEF,
  parameter int MAX_Y = MAX_Y_DEF,
  parameter int MAX_Z = MAX_Z_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DAT_W-1:0]       cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [SUM_W-1:0]           value_i,
  input  logic signed [COEF_W-1:0]   plane_a_i,
  input  logic signed [COEF_W-1:0]   plane_b_i,
  input  logic signed [COEF_W-1:0]   plane_c_i,
  input  logic signed [COEF_W-1:0]   plane_d_i,
  input  logic signed [COEF_W-1:0]   normal_a_i,
  input  logic signed [COEF_W-1:0]   normal_b_i,
  input  logic signed [COEF_W-1:0]   normal_c_i,
  input  logic signed [COEF_W-1:0]   normal_d_i,
  input  logic [PITCH_W-1:0]         pitch_xy_i,
  input  logic [PITCH_W-1:0]         pitch_z_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [SUM_W-1:0]           sum_o
);

  localparam int DEPTH    = MAX_X * MAX_Y * MAX_Z;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW       = $clog2(DEPTH + 1);
  localparam int CXW      = $clog2(MAX_X + 1);
  localparam int CYW      = $clog2(MAX_Y + 1);
  localparam int CZW      = $clog2(MAX_Z + 1);
  localparam int PROD_W   = COEF_W + COORD_W;
  localparam int DIST_W   = PROD_W + 2;
  localparam int SIDE_LAT = DIV_LAT + SQRT_LAT + 2;
  localparam int MUL_W    = VOX_W + Q_W;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_e;

  state_e st_q;

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [ORIG_W-1:0] orig_x_q, orig_y_q, orig_z_q;

  logic [CXW-1:0] nx, l_q;
  logic [CYW-1:0] ny, j_q;
  logic [CZW-1:0] nz, k_q;
  logic [TW-1:0]  total;
  logic [AW-1:0]  idx_q;

  logic [TW-1:0]  ptr_q, ptr_d, ptr_nxt;
  logic [AW-1:0]  wr_addr;

  logic in_acc, ld_acc, ev_acc;

  logic [VOX_W:0] img_mem [DEPTH];
  logic [VOX_W:0] rd_q;

  logic signed [COEF_W-1:0] pa_q, pb_q, pc_q, pd_q, na_q, nb_q, nc_q, nd_q;
  logic [PITCH_W-1:0]       pxy_q, pz_q;
  logic [SUM_W-1:0]         acc_q, acc_d;
  logic [SUM_W:0]           acc_ext;

  logic signed [COORD_W-1:0] x1_q, y1_q, z1_q;
  logic signed [PROD_W-1:0]  mnx2_q, mny2_q, mnz2_q, mpx2_q, mpy2_q, mpz2_q;
  logic [VOX_W-1:0]          vox2_q, vox3_q, vox4_q, vox5_q;
  logic signed [PROD_W:0]    ay3_q, by3_q, az3_q, bz3_q;
  logic signed [DIST_W-1:0]  dy4_q, dz4_q;
  logic [DIST_W-1:0]         magy, magz;
  logic [PITCH_W-1:0]        my5_q, mz5_q;
  logic                      v1_q, v2_q, v3_q, v4_q, p5_q;

  logic [Q_W-1:0]   qy_raw, qz_raw, qy, qz, root, wgt;
  logic [RAD_W-1:0] sqy_q, sqz_q, rad_q;

  logic [SIDE_LAT-1:0] side_p_q;
  logic [VOX_W-1:0]    side_v_q [SIDE_LAT];
  logic [MUL_W-1:0]    prod_q;
  logic                acc_en_q, live, in_flight;

  logic             out_valid_q;
  logic [SUM_W-1:0] sum_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sum_o       = sum_q;

  assign in_acc = in_valid_i && !in_stall_o;
  assign ld_acc = in_acc && (op_i == OP_LOAD_OUT || op_i == OP_LOAD_IN);
  assign ev_acc = in_acc && (op_i == OP_EVENT);

  assign nx = (32'(size_x_q) > MAX_X) ? CXW'(MAX_X) : CXW'(size_x_q);
  assign ny = (32'(size_y_q) > MAX_Y) ? CYW'(MAX_Y) : CYW'(size_y_q);
  assign nz = (32'(size_z_q) > MAX_Z) ? CZW'(MAX_Z) : CZW'(size_z_q);
  assign total = TW'(nx) * TW'(ny) * TW'(nz);

  assign wr_addr = (ptr_q < TW'(DEPTH)) ? ptr_q[AW-1:0] : '0;
  assign ptr_nxt = TW'(wr_addr) + TW'(1);
  assign ptr_d   = (ptr_nxt >= total) ? '0 : ptr_nxt;

  assign in_flight = v1_q || v2_q || v3_q || v4_q || p5_q || (|side_p_q) || acc_en_q;

  // image memory: value plus mask bit
  always_ff @(posedge clk_i) begin
    if (ld_acc) begin
      img_mem[wr_addr] <= {op_i[0], value_i[VOX_W-1:0]};
    end
    if (st_q == ST_RUN) begin
      rd_q <= img_mem[idx_q];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      size_x_q    <= SIZE_W'(32);
      size_y_q    <= SIZE_W'(32);
      size_z_q    <= SIZE_W'(32);
      orig_x_q    <= '0;
      orig_y_q    <= '0;
      orig_z_q    <= '0;
      ptr_q       <= '0;
      idx_q       <= '0;
      l_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      p5_q        <= 1'b0;
      side_p_q    <= '0;
      acc_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SIZE_X:   size_x_q <= cfg_data_i[SIZE_W-1:0];
          REG_SIZE_Y:   size_y_q <= cfg_data_i[SIZE_W-1:0];
          REG_SIZE_Z:   size_z_q <= cfg_data_i[SIZE_W-1:0];
          REG_ORIGIN_X: orig_x_q <= cfg_data_i;
          REG_ORIGIN_Y: orig_y_q <= cfg_data_i;
          REG_ORIGIN_Z: orig_z_q <= cfg_data_i;
          default: ;
        endcase
      end

      v1_q     <= (st_q == ST_RUN);
      v2_q     <= v1_q && rd_q[VOX_W];
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      p5_q     <= v4_q && (magy <= DIST_W'(pz_q)) && (magz <= DIST_W'(pxy_q));
      side_p_q <= {side_p_q[SIDE_LAT-2:0], p5_q};
      acc_en_q <= live;

      if (st_q == ST_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (ld_acc) begin
            ptr_q <= ptr_d;
          end
          if (ev_acc) begin
            idx_q <= '0;
            l_q   <= '0;
            j_q   <= '0;
            k_q   <= '0;
            st_q  <= (total == '0) ? ST_DRAIN : ST_RUN;
          end
        end
        ST_RUN: begin
          idx_q <= idx_q + AW'(1);
          if (k_q == nz - CZW'(1)) begin
            k_q <= '0;
            if (j_q == ny - CYW'(1)) begin
              j_q <= '0;
              if (l_q == nx - CXW'(1)) begin
                st_q <= ST_DRAIN;
              end else begin
                l_q <= l_q + CXW'(1);
              end
            end else begin
              j_q <= j_q + CYW'(1);
            end
          end else begin
            k_q <= k_q + CZW'(1);
          end
        end
        ST_DRAIN: begin
          if (!in_flight) begin
            st_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            sum_q <= acc_q;
            st_q  <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  assign magy = dy4_q[DIST_W-1] ? DIST_W'(-dy4_q) : DIST_W'(dy4_q);
  assign magz = dz4_q[DIST_W-1] ? DIST_W'(-dz4_q) : DIST_W'(dz4_q);

  assign qy   = (pz_q == '0) ? '0 : qy_raw;
  assign qz   = (pxy_q == '0) ? '0 : qz_raw;
  assign live = side_p_q[SIDE_LAT-1] && (root < ONE_Q16);
  assign wgt  = ONE_Q16 - root;

  assign acc_ext = {1'b0, acc_q} + (SUM_W + 1)'(prod_q[MUL_W-1:16]);
  assign acc_d   = acc_ext[SUM_W] ? '1 : acc_ext[SUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ev_acc) begin
      pa_q  <= plane_a_i;
      pb_q  <= plane_b_i;
      pc_q  <= plane_c_i;
      pd_q  <= plane_d_i;
      na_q  <= normal_a_i;
      nb_q  <= normal_b_i;
      nc_q  <= normal_c_i;
      nd_q  <= normal_d_i;
      pxy_q <= pitch_xy_i;
      pz_q  <= pitch_z_i;
      acc_q <= value_i;
    end else if (acc_en_q) begin
      acc_q <= acc_d;
    end

    x1_q <= {orig_x_q[ORIG_W-1], orig_x_q} + COORD_W'(l_q);
    y1_q <= {orig_y_q[ORIG_W-1], orig_y_q} + COORD_W'(j_q);
    z1_q <= {orig_z_q[ORIG_W-1], orig_z_q} + COORD_W'(k_q);

    mnx2_q <= na_q * x1_q;
    mny2_q <= nb_q * y1_q;
    mnz2_q <= nc_q * z1_q;
    mpx2_q <= pa_q * x1_q;
    mpy2_q <= pb_q * y1_q;
    mpz2_q <= pc_q * z1_q;
    vox2_q <= rd_q[VOX_W-1:0];

    ay3_q  <= mnx2_q + mny2_q;
    by3_q  <= mnz2_q - nd_q;
    az3_q  <= mpx2_q + mpy2_q;
    bz3_q  <= mpz2_q - pd_q;
    vox3_q <= vox2_q;

    dy4_q  <= ay3_q + by3_q;
    dz4_q  <= az3_q + bz3_q;
    vox4_q <= vox3_q;

    my5_q  <= magy[PITCH_W-1:0];
    mz5_q  <= magz[PITCH_W-1:0];
    vox5_q <= vox4_q;

    side_v_q[0] <= vox5_q;
    for (int i = 1; i < SIDE_LAT; i++) begin
      side_v_q[i] <= side_v_q[i-1];
    end

    sqy_q <= RAD_W'(qy) * RAD_W'(qy);
    sqz_q <= RAD_W'(qz) * RAD_W'(qz);
    rad_q <= sqy_q + sqz_q;

    prod_q <= MUL_W'(side_v_q[SIDE_LAT-1]) * MUL_W'(wgt);
  end

  ofp_div u_div_y (
    .clk_i (clk_i),
    .num_i (my5_q),
    .den_i (pz_q),
    .quo_o (qy_raw)
  );

  ofp_div u_div_z (
    .clk_i (clk_i),
    .num_i (mz5_q),
    .den_i (pxy_q),
    .quo_o (qz_raw)
  );

  ofp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad_q),
    .root_o (root)
  );

  `OFP_NEVER(a_idle_pipe_empty, st_q == ST_IDLE && in_flight, "voxel in flight while idle")
  `OFP_ASSERT(a_acc_rising, (st_q == ST_RUN || st_q == ST_DRAIN) |=> acc_q >= $past(acc_q), "sum fell")
  `OFP_ASSERT(a_walk_in_range, st_q == ST_RUN |-> TW'(idx_q) < total, "walk beyond volume")
  `OFP_ASSERT(a_fin_emits, st_q == ST_FIN && !(out_valid_q && out_stall_i) |=> out_valid_q && st_q == ST_IDLE, "event result lost")

endmodule

// ===== design/ofp_div.sv =====
`timescale 1ns / 1ps

module ofp_div import ofp_pkg::*; (
  input  logic               clk_i,
  input  logic [PITCH_W-1:0] num_i,
  input  logic [PITCH_W-1:0] den_i,
  output logic [Q_W-1:0]     quo_o
);

  logic [PITCH_W-1:0] rem_q [DIV_LAT];
  logic [Q_W-1:0]     quo_q [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [PITCH_W:0]   r2;
    logic [PITCH_W:0]   diff;
    logic [Q_W-1:0]     quo_in;
    logic               bit_set;

    if (i == 0) begin : g_first
      assign r2     = {1'b0, num_i};
      assign quo_in = '0;
    end else begin : g_next
      assign r2     = {rem_q[i-1], 1'b0};
      assign quo_in = quo_q[i-1];
    end

    assign diff    = r2 - {1'b0, den_i};
    assign bit_set = r2 >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      quo_q[i] <= {quo_in[Q_W-2:0], bit_set};
    end

    if (i < DIV_LAT - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[i] <= bit_set ? diff[PITCH_W-1:0] : r2[PITCH_W-1:0];
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule

// ===== design/ofp_sqrt.sv =====
`timescale 1ns / 1ps

module ofp_sqrt import ofp_pkg::*; (
  input  logic             clk_i,
  input  logic [RAD_W-1:0] rad_i,
  output logic [Q_W-1:0]   root_o
);

  logic [RAD_W-1:0] rad_q  [SQRT_LAT];
  logic [REM_W-1:0] rem_q  [SQRT_LAT];
  logic [Q_W-1:0]   root_q [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    localparam int P = SQRT_LAT - 1 - i;
    logic [RAD_W-1:0] rad_in;
    logic [REM_W-1:0] rem_in;
    logic [Q_W-1:0]   root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[2*P+1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      root_q[i] <= {root_in[Q_W-2:0], rem_sh >= trial};
    end

    if (i < SQRT_LAT - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rad_q[i] <= rad_in;
        rem_q[i] <= (rem_sh >= trial) ? rem_sh - trial : rem_sh;
      end
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule
